### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle check");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle check");

`endif

### rtl/ledseq_pkg.sv
package ledseq_pkg;

    // Pattern mode, as reported on the result channel.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_FADE  = 2'd2,
        MODE_SOLID = 2'd3
    } mode_t;

    // Request kinds carried on s_tuser.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SOLID = 2'd1,
        OP_BLINK = 2'd2,
        OP_FADE  = 2'd3
    } opcode_t;

    localparam logic [7:0] LEVEL_MAX       = 8'd255;
    localparam logic [7:0] FADE_STEP_RESET = 8'd4;
    localparam logic [1:0] LAST_PHASE      = 2'd2;

    // Color for one step of the boot fade: red to blue, blue to green,
    // green to red.
    function automatic logic [23:0] fade_color(input logic [1:0] phase,
                                               input logic [7:0] step);
        logic [7:0]  down;
        logic [23:0] col;
        down = LEVEL_MAX - step;
        case (phase)
            2'd0:    col = {down, 8'd0, step};
            2'd1:    col = {8'd0, step, down};
            2'd2:    col = {step, down, 8'd0};
            default: col = 24'd0;
        endcase
        return col;
    endfunction

endpackage

### rtl/led_blink_fade_pattern_sequencer.sv
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       s_tuser opcode, s_tdata color, count, interval
// m_        out        m_tvalid / m_tready       m_tdata led color, m_tuser updated flag, mode
// cfg_      in         cfg_valid / cfg_ready     cfg_data fade step interval in ticks
//
// Every request produces exactly one result, loaded into the result register when it is accepted.
// A request can be accepted in every cycle while the result register is free;
// the pattern state and the result register are both written at the accepting edge.
// s_tready is low only while the result register holds a result that the
// downstream side has not yet taken.
// Reset (aresetn low, synchronous) leaves the LED off, the mode idle and the
// fade step interval at four ticks. cfg_ready is always high.
module led_blink_fade_pattern_sequencer
    import ledseq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] color, [31:24] blink_count, [47:32] interval_ticks
    input  logic [1:0]  s_tuser,   // [1:0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] led_color
    output logic [2:0]  m_tuser,   // [0] color_updated, [2:1] mode

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    // Request fields.
    logic [23:0] in_color;
    logic [7:0]  in_count;
    logic [15:0] in_interval;
    opcode_t     in_op;

    assign in_color    = s_tdata[23:0];
    assign in_count    = s_tdata[31:24];
    assign in_interval = s_tdata[47:32];
    assign in_op       = opcode_t'(s_tuser);

    // Pattern state.
    logic [7:0]  fade_ticks_reg;
    mode_t       mode_reg,        mode_next;
    logic [23:0] saved_color_reg, saved_color_next;
    logic [23:0] flash_color_reg, flash_color_next;
    logic [7:0]  blinks_left_reg, blinks_left_next;
    logic [15:0] half_period_reg, half_period_next;
    logic        lamp_on_reg,     lamp_on_next;
    logic [15:0] ticks_reg,       ticks_next;
    logic [1:0]  fade_phase_reg,  fade_phase_next;
    logic [7:0]  fade_step_reg,   fade_step_next;
    logic [23:0] shown_reg,       shown_next;
    logic        updated_next;

    // Result register.
    logic        m_tvalid_reg;
    logic [23:0] m_color_reg;
    logic        m_updated_reg;
    mode_t       m_mode_reg;

    logic        s_accept;
    logic [15:0] ticks_inc;

    // The result register is free when it is empty or is being emptied now.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_color_reg;
    assign m_tuser  = {m_mode_reg, m_updated_reg};

    // The elapsed-tick counter saturates at its top value.
    assign ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;

    always_comb begin
        mode_next        = mode_reg;
        saved_color_next = saved_color_reg;
        flash_color_next = flash_color_reg;
        blinks_left_next = blinks_left_reg;
        half_period_next = half_period_reg;
        lamp_on_next     = lamp_on_reg;
        ticks_next       = ticks_reg;
        fade_phase_next  = fade_phase_reg;
        fade_step_next   = fade_step_reg;
        shown_next       = shown_reg;
        updated_next     = 1'b0;

        case (in_op)
            OP_TICK: begin
                ticks_next = ticks_inc;
                case (mode_reg)
                    MODE_SOLID: begin
                        // A solid color is kept; the engine simply goes idle.
                        mode_next = MODE_IDLE;
                    end
                    MODE_BLINK: begin
                        if (blinks_left_reg == 8'd0) begin
                            // Blinks used up: restore the stored solid color.
                            shown_next   = saved_color_reg;
                            mode_next    = MODE_SOLID;
                            updated_next = 1'b1;
                        end else if (ticks_inc >= half_period_reg) begin
                            if (lamp_on_reg) begin
                                shown_next       = 24'd0;
                                blinks_left_next = blinks_left_reg - 8'd1;
                            end else begin
                                shown_next = flash_color_reg;
                            end
                            lamp_on_next = !lamp_on_reg;
                            ticks_next   = 16'd0;
                            updated_next = 1'b1;
                        end
                    end
                    MODE_FADE: begin
                        if (ticks_inc >= {8'd0, fade_ticks_reg}) begin
                            shown_next = fade_color(fade_phase_reg, fade_step_reg);
                            if (fade_step_reg == LEVEL_MAX) begin
                                fade_step_next = 8'd0;
                                if (fade_phase_reg >= LAST_PHASE) begin
                                    // Last step of the last phase: LED off, idle.
                                    shown_next      = 24'd0;
                                    fade_phase_next = 2'd0;
                                    mode_next       = MODE_IDLE;
                                end else begin
                                    fade_phase_next = fade_phase_reg + 2'd1;
                                end
                            end else begin
                                fade_step_next = fade_step_reg + 8'd1;
                            end
                            ticks_next   = 16'd0;
                            updated_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_SOLID: begin
                saved_color_next = in_color;
                shown_next       = in_color;
                mode_next        = MODE_SOLID;
                updated_next     = 1'b1;
            end
            OP_BLINK: begin
                mode_next        = MODE_BLINK;
                flash_color_next = in_color;
                blinks_left_next = in_count;
                half_period_next = in_interval;
                shown_next       = in_color;
                lamp_on_next     = 1'b1;
                ticks_next       = 16'd0;
                updated_next     = 1'b1;
            end
            OP_FADE: begin
                // The shown color stays until the first fade step.
                mode_next       = MODE_FADE;
                fade_phase_next = 2'd0;
                fade_step_next  = 8'd0;
                ticks_next      = 16'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_ticks_reg  <= FADE_STEP_RESET;
            mode_reg        <= MODE_IDLE;
            saved_color_reg <= 24'd0;
            flash_color_reg <= 24'd0;
            blinks_left_reg <= 8'd0;
            half_period_reg <= 16'd0;
            lamp_on_reg     <= 1'b0;
            ticks_reg       <= 16'd0;
            fade_phase_reg  <= 2'd0;
            fade_step_reg   <= 8'd0;
            shown_reg       <= 24'd0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                fade_ticks_reg <= cfg_data;
            end
            if (s_accept) begin
                mode_reg        <= mode_next;
                saved_color_reg <= saved_color_next;
                flash_color_reg <= flash_color_next;
                blinks_left_reg <= blinks_left_next;
                half_period_reg <= half_period_next;
                lamp_on_reg     <= lamp_on_next;
                ticks_reg       <= ticks_next;
                fade_phase_reg  <= fade_phase_next;
                fade_step_reg   <= fade_step_next;
                shown_reg       <= shown_next;
            end
            m_tvalid_reg <= s_accept || (m_tvalid_reg && !m_tready);
        end
    end

    // Result payload needs no reset; it is loaded with every accepted request.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_color_reg   <= shown_next;
            m_updated_reg <= updated_next;
            m_mode_reg    <= mode_next;
        end
    end

endmodule

### rtl/ledseq_checker.sv
`include "assert_macros.svh"

module ledseq_checker
    import ledseq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // A solid request shows its color, flagged as updated, in solid mode.
    `ASSERT_NEXT(a_solid_shown, aclk, aresetn, s_acc && (s_tuser == OP_SOLID),
        m_tvalid && (m_tdata == $past(s_tdata[23:0])) && (m_tuser == {MODE_SOLID, 1'b1}))

    // A blink request shows its color at once and enters blink mode.
    `ASSERT_NEXT(a_blink_start, aclk, aresetn, s_acc && (s_tuser == OP_BLINK),
        m_tvalid && (m_tdata == $past(s_tdata[23:0])) && (m_tuser == {MODE_BLINK, 1'b1}))

    // A fade request enters fade mode without touching the shown color.
    `ASSERT_NEXT(a_fade_start, aclk, aresetn, s_acc && (s_tuser == OP_FADE),
        m_tvalid && (m_tuser == {MODE_FADE, 1'b0}))

    // A stalled result stays offered.
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind led_blink_fade_pattern_sequencer ledseq_checker u_ledseq_checker (.*);

### dv/tb_led_blink_fade_pattern_sequencer.sv
`timescale 1ns / 1ps

module tb_led_blink_fade_pattern_sequencer;
    import ledseq_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;
    // Random requests per fade step setting.
    localparam int PHASE_ITEMS   = 45;
    // The receiver holds off once, after this many results, for this long.
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 250;

    // One LED result: shown color, refresh flag and pattern mode.
    typedef struct packed {
        logic [23:0] color;
        logic        updated;
        mode_t       mode;
    } led_result_t;

    // Tracks the LED pattern engine and checks each result in order.
    class led_pattern_scoreboard;
        mode_t        mode;
        logic [23:0]  solid_color;
        logic [23:0]  flash_color;
        logic [23:0]  shown;
        logic [7:0]   blinks_left;
        logic [15:0]  half_period;
        logic         lamp_on;
        logic [15:0]  elapsed;
        logic [1:0]   fade_phase;
        logic [7:0]   fade_step;
        logic [7:0]   step_ticks;
        led_result_t  expected_leds[$];
        int           requests;
        int           checked;
        int           errors;

        function new();
            mode        = MODE_IDLE;
            solid_color = '0;
            flash_color = '0;
            shown       = '0;
            blinks_left = '0;
            half_period = '0;
            lamp_on     = 1'b0;
            elapsed     = '0;
            fade_phase  = '0;
            fade_step   = '0;
            step_ticks  = FADE_STEP_RESET;
            requests    = 0;
            checked     = 0;
            errors      = 0;
        endfunction

        function void set_step_ticks(logic [7:0] value);
            step_ticks = value;
        endfunction

        // Advances the pattern by one millisecond tick; returns 1 when the
        // shown color was written.
        function logic advance_tick();
            logic [7:0] rise;
            logic [7:0] fall;
            if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
            case (mode)
                MODE_SOLID: begin
                    mode = MODE_IDLE;
                    return 1'b0;
                end
                MODE_BLINK: begin
                    if (blinks_left == 8'd0) begin
                        shown = solid_color;
                        mode  = MODE_SOLID;
                        return 1'b1;
                    end
                    if (elapsed >= half_period) begin
                        if (lamp_on) begin
                            shown       = 24'd0;
                            blinks_left = blinks_left - 8'd1;
                        end else begin
                            shown = flash_color;
                        end
                        lamp_on = !lamp_on;
                        elapsed = 16'd0;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                MODE_FADE: begin
                    if (elapsed >= {8'd0, step_ticks}) begin
                        rise = fade_step;
                        fall = LEVEL_MAX - fade_step;
                        case (fade_phase)
                            2'd0:    shown = {fall, 8'd0, rise};
                            2'd1:    shown = {8'd0, rise, fall};
                            2'd2:    shown = {rise, fall, 8'd0};
                            default: shown = 24'd0;
                        endcase
                        if (fade_step == LEVEL_MAX) begin
                            fade_step = 8'd0;
                            if (fade_phase >= LAST_PHASE) begin
                                // The last step of the last phase turns the LED off.
                                shown      = 24'd0;
                                fade_phase = 2'd0;
                                mode       = MODE_IDLE;
                            end else begin
                                fade_phase = fade_phase + 2'd1;
                            end
                        end else begin
                            fade_step = fade_step + 8'd1;
                        end
                        elapsed = 16'd0;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_request(opcode_t op, logic [23:0] col, logic [7:0] cnt,
                                   logic [15:0] itv);
            led_result_t res;
            logic        upd;
            upd = 1'b0;
            case (op)
                OP_TICK: upd = advance_tick();
                OP_SOLID: begin
                    solid_color = col;
                    shown       = col;
                    mode        = MODE_SOLID;
                    upd         = 1'b1;
                end
                OP_BLINK: begin
                    mode        = MODE_BLINK;
                    flash_color = col;
                    blinks_left = cnt;
                    half_period = itv;
                    shown       = col;
                    lamp_on     = 1'b1;
                    elapsed     = 16'd0;
                    upd         = 1'b1;
                end
                default: begin
                    mode       = MODE_FADE;
                    fade_phase = 2'd0;
                    fade_step  = 8'd0;
                    elapsed    = 16'd0;
                end
            endcase
            res.color   = shown;
            res.updated = upd;
            res.mode    = mode;
            expected_leds.push_back(res);
            requests++;
        endfunction

        function void check_result(logic [23:0] col, logic upd, logic [1:0] md);
            led_result_t exp_res;
            if (expected_leds.size() == 0) begin
                $error("result with nothing expected: led_color %06h", col);
                errors++;
                return;
            end
            exp_res = expected_leds.pop_front();
            checked++;
            if (col !== exp_res.color) begin
                $error("led_color: expected %06h, got %06h", exp_res.color, col);
                errors++;
            end
            if (upd !== exp_res.updated) begin
                $error("color_updated: expected %0d, got %0d", exp_res.updated, upd);
                errors++;
            end
            if (md !== exp_res.mode) begin
                $error("mode: expected %0d, got %0d", exp_res.mode, md);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [23:0] color, [31:24] blink_count, [47:32] interval_ticks
    logic [1:0]  s_tuser;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [23:0] led_color
    logic [2:0]  m_tuser;   // [0] color_updated, [2:1] mode
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    led_pattern_scoreboard sb = new();

    // When set, neither side inserts idle cycles.
    bit no_gaps = 1'b0;
    int stall_cycles = 0;

    led_blink_fade_pattern_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // The watchdog ends the run if no request, result or register write is
    // accepted for too long. The longest legal quiet stretch is the
    // receiver's hold-off, well under the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: checks every accepted result at the rising edge and
    // decides m_tready at the falling edge. Once, the receiver stops for a
    // long stretch so that the result register fills and s_tready drops.
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0], m_tuser[2:1]);
            @(negedge aclk);
            if (!held && sb.checked >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Offers one request, with a random idle gap in front of it, and
    // records it in the scoreboard when it is accepted. Starts and ends at a
    // falling edge; s_tvalid stays high when the next request follows at once.
    task automatic send_request(input opcode_t op, input logic [23:0] col,
                                input logic [7:0] cnt, input logic [15:0] itv);
        while (!no_gaps && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {itv, cnt, col};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, col, cnt, itv);
        @(negedge aclk);
    endtask

    // Ticks carry random payload bits, which the block must ignore.
    task automatic send_ticks(input int count);
        logic [23:0] col;
        logic [7:0]  cnt;
        logic [15:0] itv;
        for (int i = 0; i < count; i++) begin
            col = 24'($urandom);
            cnt = 8'($urandom);
            itv = 16'($urandom);
            send_request(OP_TICK, col, cnt, itv);
        end
    endtask

    // One random scenario: mostly a pattern start followed by a random run of
    // ticks, sometimes a lone request with fully random fields.
    task automatic run_random_scenario();
        int          roll;
        int          run_len;
        opcode_t     op;
        logic [23:0] col;
        logic [7:0]  cnt;
        logic [15:0] itv;
        col  = 24'($urandom);
        cnt  = 8'($urandom);
        itv  = 16'($urandom);
        roll = int'($urandom_range(0, 99));
        if (roll < 45) begin
            if ($urandom_range(0, 99) < 75) cnt = 8'($urandom_range(0, 4));
            roll = int'($urandom_range(0, 99));
            if (roll < 60)      itv = 16'($urandom_range(0, 3));
            else if (roll < 92) itv = 16'($urandom_range(4, 12));
            run_len = 2 * (int'(cnt) + 1) * (int'(itv) + 1) + 2;
            if (run_len > 60) run_len = 60;
            if ($urandom_range(0, 3) == 0) run_len = int'($urandom_range(0, run_len));
            send_request(OP_BLINK, col, cnt, itv);
            send_ticks(run_len);
        end else if (roll < 60) begin
            send_request(OP_SOLID, col, cnt, itv);
            send_ticks(int'($urandom_range(0, 3)));
        end else if (roll < 75) begin
            send_request(OP_FADE, col, cnt, itv);
            send_ticks(int'($urandom_range(0, 40)));
        end else begin
            case ($urandom_range(0, 3))
                0:       op = OP_TICK;
                1:       op = OP_SOLID;
                2:       op = OP_BLINK;
                default: op = OP_FADE;
            endcase
            send_request(op, col, cnt, itv);
        end
    endtask

    // Stops offering requests, waits until every result has been taken and
    // then lets the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_leds.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_fade_ticks(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_step_ticks(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0] settings[5];
        int         start_count;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TICK;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset fade step setting of four ticks.
        send_request(OP_TICK, 24'h000000, 8'h00, 16'h0000);   // tick while idle
        send_request(OP_SOLID, 24'hFFFFFF, 8'hFF, 16'hFFFF);
        send_ticks(2);                                        // solid drops to idle
        send_request(OP_SOLID, 24'h000000, 8'h00, 16'h0000);
        // A blink with no count shows its color and the next tick restores solid.
        send_request(OP_BLINK, 24'hA5A5A5, 8'h00, 16'hFFFF);
        send_ticks(1);
        // A zero interval toggles on every tick.
        send_request(OP_BLINK, 24'h5A5A5A, 8'h01, 16'h0000);
        send_ticks(3);
        send_request(OP_SOLID, 24'h123456, 8'h00, 16'h0000);
        send_request(OP_BLINK, 24'hFF00FF, 8'hFF, 16'h0002);
        send_ticks(3);
        // A fade start aborts the blink and leaves the shown color alone.
        send_request(OP_FADE, 24'hFFFFFF, 8'hFF, 16'hFFFF);
        send_ticks(5);
        send_request(OP_BLINK, 24'h00FF00, 8'h02, 16'h0001);
        send_request(OP_FADE, 24'h000000, 8'h00, 16'h0000);
        send_request(OP_SOLID, 24'h0F0F0F, 8'h80, 16'h8000);
        drain_results();

        // Random part across several fade step settings, including both ends
        // of the range and zero, which makes the fade step on every tick.
        settings[0] = 8'd255;
        settings[1] = 8'd0;
        settings[2] = 8'd1;
        settings[3] = 8'd2;
        settings[4] = 8'($urandom_range(3, 254));
        for (int p = 0; p < 5; p++) begin
            write_fade_ticks(settings[p]);
            // One phase runs with no idle cycles on either side.
            no_gaps = (p == 3);
            if (p == 2) begin
                // A complete boot fade: three phases of 256 steps, one step
                // per tick, ending with the LED off and the mode idle.
                send_request(OP_FADE, 24'hC3C3C3, 8'h00, 16'h0000);
                send_ticks(770);
            end
            start_count = sb.requests;
            while (sb.requests - start_count < PHASE_ITEMS) run_random_scenario();
            drain_results();
        end
        no_gaps = 1'b0;

        $display("Sent %0d requests and checked %0d results under six fade step settings,",
                 sb.requests, sb.checked);
        $display("including a complete boot fade and a long receiver hold-off.");
        if (sb.errors == 0 && sb.expected_leds.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
